>>> rtl/core/ftba_pkg.sv
// ============================================================================
// Flow accounting package
// Types, codes and bit positions shared by the flow byte accounting block,
// its entry cells and its port checker.
// ============================================================================
package ftba_pkg;

    localparam int OP_W         = 2;
    localparam int IP_W         = 32;
    localparam int PROTO_W      = 8;
    localparam int PORT_W       = 16;
    localparam int LEN_W        = 16;
    localparam int READ_INDEX_W = 6;
    localparam int STATUS_W     = 3;
    localparam int FLOW_INDEX_W = 6;
    localparam int FLOW_COUNT_W = 7;
    localparam int BYTES_W      = 32;
    localparam int RANK_W       = 2;
    localparam int MAX_RESULTS  = 3;

    localparam logic [PROTO_W-1:0] TCP_PROTO_NUM = 8'd6;
    localparam logic [PROTO_W-1:0] UDP_PROTO_NUM = 8'd17;

    // Input beat layout, lowest bit first.
    localparam int IN_SRC_IP_LSB = 0;
    localparam int IN_DST_IP_LSB = 32;
    localparam int IN_PROTO_LSB  = 64;
    localparam int IN_SPORT_LSB  = 72;
    localparam int IN_DPORT_LSB  = 88;
    localparam int IN_LEN_LSB    = 104;
    localparam int IN_READ_LSB   = 120;
    localparam int S_TDATA_W     = 128;

    // Result beat layout, lowest bit first.
    localparam int OUT_IDX_LSB    = 0;
    localparam int OUT_CNT_LSB    = 6;
    localparam int OUT_BYTES_LSB  = 13;
    localparam int OUT_SRC_IP_LSB = 45;
    localparam int OUT_DST_IP_LSB = 77;
    localparam int OUT_PROTO_LSB  = 109;
    localparam int OUT_SPORT_LSB  = 117;
    localparam int OUT_DPORT_LSB  = 133;
    localparam int OUT_RANK_LSB   = 149;
    localparam int OUT_USED_W     = 151;
    localparam int M_TDATA_W      = 152;

    typedef enum logic [OP_W-1:0] {
        OP_PACKET = 2'd0,
        OP_READ   = 2'd1,
        OP_TOP    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NEW      = 3'd0,
        STATUS_EXISTING = 3'd1,
        STATUS_DROPPED  = 3'd2,
        STATUS_ENTRY    = 3'd3,
        STATUS_NO_ENTRY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SWEEP  = 3'd1,
        S_MATCH  = 3'd2,
        S_GATHER = 3'd3,
        S_COMMIT = 3'd4
    } state_t;

    typedef struct packed {
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    dst_ip;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
    } key_t;

    typedef struct packed {
        logic capture;
        logic by_index;
        logic wr_sum;
        logic wr_new;
    } cell_cmd_t;

endpackage

>>> rtl/core/five_tuple_flow_byte_accounting.sv
// ============================================================================
// Five-tuple flow byte accounting
// Flow table of FLOW_ENTRIES cells with exact 5-tuple match, saturating byte
// totals, entry read, top flow report and table clear.
// ============================================================================
//
//  Channel | Handshake         | Payload
//  input   | s_tvalid s_tready | s_tuser op, s_tdata packet and read fields
//  result  | m_tvalid m_tready | m_tuser status, m_tdata entry and rank, m_tlast
//
//  A packet or read beat passes through accept, cell compare, gather and commit.
//  A top report takes the accept step, a sweep while the ranking list passes
//  through the cell chain, then cell compare, gather and commit per reported flow.
//  A clear is done in the accept step.
//  Of the table, reset clears only the flow count; entries are not cleared.
//  The commit cycle waits while the result register holds an untaken beat.
//
module five_tuple_flow_byte_accounting
    import ftba_pkg::*;
#(
    parameter int FLOW_ENTRIES = 64,
    parameter int TOP_COUNT    = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // source address, destination address, protocol, source port,
    // destination port, frame length, read index
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // flow_index, flow_count, byte_total, key source address, key destination
    // address, key protocol, key source port, key destination port, rank
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]  m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam int SEL_W = (IDX_W > READ_INDEX_W) ? IDX_W : READ_INDEX_W;
    localparam int TOP_N = (TOP_COUNT < MAX_RESULTS) ? TOP_COUNT : MAX_RESULTS;

    state_t                      state_reg, state_next;
    op_t                         op_reg, op_next;
    key_t                        req_key_reg, req_key_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [READ_INDEX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            sweep_reg, sweep_next;
    logic [TOP_N-1:0]            top_v_reg, top_v_next;
    logic [TOP_N-1:0][IDX_W-1:0] top_i_reg, top_i_next;
    logic [RANK_W-1:0]           rank_reg, rank_next;
    key_t                        g_key_reg, g_key_next;
    logic [BYTES_W-1:0]          g_bytes_reg, g_bytes_next;
    logic [IDX_W-1:0]            g_idx_reg, g_idx_next;
    logic                        g_hit_reg, g_hit_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]         m_tuser_reg, m_tuser_next;
    logic                        m_tlast_reg, m_tlast_next;

    cell_cmd_t                   cmd;
    logic [SEL_W-1:0]            sel_index;
    logic [BYTES_W-1:0]          wr_bytes;

    logic [FLOW_ENTRIES-1:0]     cell_sel;
    key_t                        cell_key   [FLOW_ENTRIES];
    logic [BYTES_W-1:0]          cell_bytes [FLOW_ENTRIES];
    logic [TOP_N-1:0]            chain_v    [FLOW_ENTRIES+1];
    logic [TOP_N-1:0][BYTES_W-1:0] chain_b  [FLOW_ENTRIES+1];
    logic [TOP_N-1:0][IDX_W-1:0] chain_i    [FLOW_ENTRIES+1];

    key_t                        in_key;
    logic [PROTO_W-1:0]          in_proto;
    logic                        in_ports;
    logic [BYTES_W:0]            sum;
    logic [BYTES_W-1:0]          sat;
    logic                        out_free;
    logic [TOP_N-1:0]            next_v;

    status_t                     r_status;
    logic [IDX_W-1:0]            r_idx;
    logic [CNT_W-1:0]            r_count;
    logic [BYTES_W-1:0]          r_bytes;
    key_t                        r_key;
    logic [RANK_W-1:0]           r_rank;
    logic                        r_last;
    logic                        emit;

    assign chain_v[0] = '0;
    assign chain_b[0] = '0;
    assign chain_i[0] = '0;

    for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
        ftba_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .SEL_W    (SEL_W),
            .TOP_N    (TOP_N)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .req_key     (req_key_reg),
            .sel_index   (sel_index),
            .count       (count_reg),
            .wr_bytes    (wr_bytes),
            .chain_v_in  (chain_v[g]),
            .chain_b_in  (chain_b[g]),
            .chain_i_in  (chain_i[g]),
            .chain_v_out (chain_v[g+1]),
            .chain_b_out (chain_b[g+1]),
            .chain_i_out (chain_i[g+1]),
            .sel         (cell_sel[g]),
            .key         (cell_key[g]),
            .bytes       (cell_bytes[g])
        );
    end

    // At most one cell is selected, so an OR over the gated cells picks it.
    always_comb begin
        g_key_next   = '0;
        g_bytes_next = '0;
        g_idx_next   = '0;
        g_hit_next   = 1'b0;
        for (int k = 0; k < FLOW_ENTRIES; k++) begin
            if (cell_sel[k]) begin
                g_key_next   = g_key_next | cell_key[k];
                g_bytes_next = g_bytes_next | cell_bytes[k];
                g_idx_next   = g_idx_next | IDX_W'(k);
                g_hit_next   = 1'b1;
            end
        end
    end

    assign in_proto = s_tdata[IN_PROTO_LSB +: PROTO_W];
    assign in_ports = (in_proto == TCP_PROTO_NUM) || (in_proto == UDP_PROTO_NUM);

    always_comb begin
        in_key.src_ip = s_tdata[IN_SRC_IP_LSB +: IP_W];
        in_key.dst_ip = s_tdata[IN_DST_IP_LSB +: IP_W];
        in_key.proto  = in_proto;
        in_key.sport  = in_ports ? s_tdata[IN_SPORT_LSB +: PORT_W] : '0;
        in_key.dport  = in_ports ? s_tdata[IN_DPORT_LSB +: PORT_W] : '0;
    end

    assign sum      = {1'b0, g_bytes_reg} + (BYTES_W + 1)'(len_reg);
    assign sat      = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign next_v   = top_v_reg >> 1;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        req_key_next  = req_key_reg;
        len_next      = len_reg;
        rd_idx_next   = rd_idx_reg;
        count_next    = count_reg;
        sweep_next    = sweep_reg;
        top_v_next    = top_v_reg;
        top_i_next    = top_i_reg;
        rank_next     = rank_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        cmd           = '0;
        sel_index     = '0;
        wr_bytes      = '0;
        r_status      = STATUS_NO_ENTRY;
        r_idx         = '0;
        r_count       = count_reg;
        r_bytes       = '0;
        r_key         = '0;
        r_rank        = '0;
        r_last        = 1'b1;
        emit          = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = op_t'(s_tuser);
                    req_key_next = in_key;
                    len_next     = s_tdata[IN_LEN_LSB +: LEN_W];
                    rd_idx_next  = s_tdata[IN_READ_LSB +: READ_INDEX_W];
                    rank_next    = '0;
                    sweep_next   = '0;
                    case (op_t'(s_tuser))
                        OP_CLEAR: count_next = '0;
                        OP_TOP:   state_next = S_SWEEP;
                        default:  state_next = S_MATCH;
                    endcase
                end
            end
            S_SWEEP: begin
                if (sweep_reg == IDX_W'(FLOW_ENTRIES - 1)) begin
                    top_v_next = chain_v[FLOW_ENTRIES];
                    top_i_next = chain_i[FLOW_ENTRIES];
                    state_next = S_MATCH;
                end else begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end
            S_MATCH: begin
                cmd.capture  = 1'b1;
                cmd.by_index = (op_reg != OP_PACKET);
                sel_index    = (op_reg == OP_READ) ? SEL_W'(rd_idx_reg) : SEL_W'(top_i_reg[0]);
                state_next   = S_GATHER;
            end
            S_GATHER: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_PACKET: begin
                            if (g_hit_reg) begin
                                r_status     = STATUS_EXISTING;
                                cmd.wr_sum   = 1'b1;
                                wr_bytes     = sat;
                                r_idx        = g_idx_reg;
                                r_bytes      = sat;
                                r_key        = g_key_reg;
                            end else if (count_reg == CNT_W'(FLOW_ENTRIES)) begin
                                r_status     = STATUS_DROPPED;
                            end else begin
                                r_status     = STATUS_NEW;
                                cmd.wr_new   = 1'b1;
                                wr_bytes     = BYTES_W'(len_reg);
                                r_idx        = IDX_W'(count_reg);
                                r_bytes      = BYTES_W'(len_reg);
                                r_key        = req_key_reg;
                                count_next   = count_reg + CNT_W'(1);
                                r_count      = count_next;
                            end
                        end
                        OP_READ: begin
                            if (g_hit_reg) begin
                                r_status = STATUS_ENTRY;
                                r_idx    = g_idx_reg;
                                r_bytes  = g_bytes_reg;
                                r_key    = g_key_reg;
                            end
                        end
                        OP_TOP: begin
                            if (top_v_reg[0]) begin
                                r_status = STATUS_ENTRY;
                                r_idx    = g_idx_reg;
                                r_bytes  = g_bytes_reg;
                                r_key    = g_key_reg;
                                r_rank   = rank_reg;
                                r_last   = !next_v[0];
                                if (next_v[0]) begin
                                    top_v_next = next_v;
                                    top_i_next = top_i_reg >> IDX_W;
                                    rank_next  = rank_reg + RANK_W'(1);
                                    state_next = S_MATCH;
                                end
                            end
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = r_status;
            m_tlast_next  = r_last;
            m_tdata_next  = {
                {(M_TDATA_W - OUT_USED_W){1'b0}},
                r_rank,
                r_key.dport,
                r_key.sport,
                r_key.proto,
                r_key.dst_ip,
                r_key.src_ip,
                r_bytes,
                FLOW_COUNT_W'(r_count),
                FLOW_INDEX_W'(r_idx)
            };
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        req_key_reg <= req_key_next;
        len_reg     <= len_next;
        rd_idx_reg  <= rd_idx_next;
        sweep_reg   <= sweep_next;
        top_v_reg   <= top_v_next;
        top_i_reg   <= top_i_next;
        rank_reg    <= rank_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (state_reg == S_GATHER) begin
            g_key_reg   <= g_key_next;
            g_bytes_reg <= g_bytes_next;
            g_idx_reg   <= g_idx_next;
            g_hit_reg   <= g_hit_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/core/ftba_cell.sv
// ============================================================================
// Flow table cell
// Holds one flow entry, compares it against the broadcast key or index, and
// inserts its total into the ranking list that moves one cell per cycle.
// ============================================================================
module ftba_cell
    import ftba_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int SEL_W    = 6,
    parameter int TOP_N    = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cell_cmd_t                       cmd,
    input  key_t                            req_key,
    input  logic [SEL_W-1:0]                sel_index,
    input  logic [CNT_W-1:0]                count,
    input  logic [BYTES_W-1:0]              wr_bytes,
    input  logic [TOP_N-1:0]                chain_v_in,
    input  logic [TOP_N-1:0][BYTES_W-1:0]   chain_b_in,
    input  logic [TOP_N-1:0][IDX_W-1:0]     chain_i_in,
    output logic [TOP_N-1:0]                chain_v_out,
    output logic [TOP_N-1:0][BYTES_W-1:0]   chain_b_out,
    output logic [TOP_N-1:0][IDX_W-1:0]     chain_i_out,
    output logic                            sel,
    output key_t                            key,
    output logic [BYTES_W-1:0]              bytes
);

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
    localparam logic [SEL_W-1:0] MY_SEL = SEL_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    key_t                          key_reg;
    logic [BYTES_W-1:0]            bytes_reg;
    logic                          sel_reg;
    logic [TOP_N-1:0]              cv_reg, cv_next;
    logic [TOP_N-1:0][BYTES_W-1:0] cb_reg, cb_next;
    logic [TOP_N-1:0][IDX_W-1:0]   ci_reg, ci_next;

    logic                          live;
    logic                          sel_next;
    logic [TOP_N-1:0]              ge, ge_prev, sh_v;
    logic [TOP_N-1:0][BYTES_W-1:0] sh_b;
    logic [TOP_N-1:0][IDX_W-1:0]   sh_i;

    assign live = MY_CNT < count;

    always_comb begin
        if (cmd.by_index) begin
            sel_next = live && (sel_index == MY_SEL);
        end else begin
            sel_next = live && (key_reg == req_key);
        end
    end

    // The list arrives sorted by descending total; an equal total from this
    // cell goes ahead, since this cell has the higher index.
    always_comb begin
        ge = '0;
        for (int j = 0; j < TOP_N; j++) begin
            ge[j] = !chain_v_in[j] || (bytes_reg >= chain_b_in[j]);
        end
        ge_prev = ge << 1;
        sh_v    = chain_v_in << 1;
        sh_b    = chain_b_in << BYTES_W;
        sh_i    = chain_i_in << IDX_W;
        cv_next = chain_v_in;
        cb_next = chain_b_in;
        ci_next = chain_i_in;
        if (live) begin
            for (int j = 0; j < TOP_N; j++) begin
                if (ge[j]) begin
                    if (ge_prev[j]) begin
                        cv_next[j] = sh_v[j];
                        cb_next[j] = sh_b[j];
                        ci_next[j] = sh_i[j];
                    end else begin
                        cv_next[j] = 1'b1;
                        cb_next[j] = bytes_reg;
                        ci_next[j] = MY_IDX;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
            cv_reg  <= '0;
        end else begin
            if (cmd.capture) begin
                sel_reg <= sel_next;
            end
            cv_reg <= cv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cb_reg <= cb_next;
        ci_reg <= ci_next;
        if (cmd.wr_new && (MY_CNT == count)) begin
            key_reg   <= req_key;
            bytes_reg <= wr_bytes;
        end else if (cmd.wr_sum && sel_reg) begin
            bytes_reg <= wr_bytes;
        end
    end

    assign chain_v_out = cv_reg;
    assign chain_b_out = cb_reg;
    assign chain_i_out = ci_reg;
    assign sel         = sel_reg;
    assign key         = key_reg;
    assign bytes       = bytes_reg;

endmodule

>>> rtl/core/ftba_checker.sv
// ============================================================================
// Flow accounting port checker
// Watches the ports of the flow byte accounting block for handshake and
// result consistency.
// ============================================================================
module ftba_checker
    import ftba_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [OP_W-1:0]      s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser,
    input logic                 m_tlast
);

    // A stalled result beat holds still.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Every beat other than a clear keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_CLEAR) |=> !s_tready)
        else $error("input taken again right after a working beat");

    // Only a top report has several results; all others are single and rank zero.
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_ENTRY) |->
            m_tlast && (m_tdata[OUT_RANK_LSB +: RANK_W] == '0))
        else $error("non-report result is not a single final beat");

    // A new flow lands at the end of the table.
    a_new_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_NEW) |->
            m_tdata[OUT_IDX_LSB +: FLOW_INDEX_W] ==
            FLOW_INDEX_W'(m_tdata[OUT_CNT_LSB +: FLOW_COUNT_W] - 7'd1))
        else $error("new flow index does not match flow count");

endmodule

bind five_tuple_flow_byte_accounting ftba_checker u_ftba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/tb_top.sv
// ============================================================================
// Flow byte accounting testbench
// Streams packet, read, top report and clear beats into the flow table.
// A flow table kept in the bench predicts every result beat, which is then
// compared field by field, while both sides of the block idle at random except in the last phase.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ftba_pkg::*;

    localparam int FLOW_ENTRIES     = 64;
    localparam int TOP_COUNT        = 3;
    localparam int CLK_HALF         = 4;
    localparam int RANDOM_PER_PHASE = 130;
    localparam int HEAVY_BEATS      = 8;
    localparam int TX_IDLE_PCT  [3] = '{14, 67, 0};
    localparam int RX_STALL_PCT [3] = '{67, 14, 0};

    typedef struct {
        op_t                     op;
        key_t                    key;
        logic [LEN_W-1:0]        frame_len;
        logic [READ_INDEX_W-1:0] read_index;
        int                      phase;
    } flow_cmd_t;

    typedef struct {
        status_t                 status;
        logic [FLOW_INDEX_W-1:0] flow_index;
        logic [FLOW_COUNT_W-1:0] flow_count;
        logic [BYTES_W-1:0]      byte_total;
        key_t                    key;
        logic [RANK_W-1:0]       rank;
        logic                    last;
    } flow_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    flow_cmd_t    pending_beats[$];
    flow_result_t awaited_results[$];
    key_t         flow_pool[$];
    flow_cmd_t    cur_cmd;
    int           cur_phase   = 0;
    int           error_count = 0;

    key_t               table_key   [FLOW_ENTRIES];
    logic [BYTES_W-1:0] table_bytes [FLOW_ENTRIES];
    int                 flows_held = 0;

    five_tuple_flow_byte_accounting #(
        .FLOW_ENTRIES(FLOW_ENTRIES),
        .TOP_COUNT   (TOP_COUNT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
        end
    endtask

    function automatic flow_result_t entry_result(status_t st, int idx, int rnk, logic fin);
        flow_result_t r;
        r.status     = st;
        r.flow_index = FLOW_INDEX_W'(idx);
        r.flow_count = FLOW_COUNT_W'(flows_held);
        r.byte_total = table_bytes[idx];
        r.key        = table_key[idx];
        r.rank       = RANK_W'(rnk);
        r.last       = fin;
        return r;
    endfunction

    function automatic flow_result_t blank_result(status_t st);
        flow_result_t r;
        r.status     = st;
        r.flow_index = '0;
        r.flow_count = FLOW_COUNT_W'(flows_held);
        r.byte_total = '0;
        r.key        = '0;
        r.rank       = '0;
        r.last       = 1'b1;
        return r;
    endfunction

    task automatic account_beat(input flow_cmd_t c);
        key_t          k;
        logic [BYTES_W:0] sum;
        bit            taken [FLOW_ENTRIES];
        int            hit;
        int            best;
        int            n;
        hit = -1;
        case (c.op)
            OP_PACKET: begin
                k = c.key;
                if (k.proto != TCP_PROTO_NUM && k.proto != UDP_PROTO_NUM) begin
                    k.sport = '0;
                    k.dport = '0;
                end
                for (int i = 0; i < flows_held; i++) begin
                    if (hit < 0 && table_key[i] == k) hit = i;
                end
                if (hit >= 0) begin
                    sum = {1'b0, table_bytes[hit]} + {{(BYTES_W+1-LEN_W){1'b0}}, c.frame_len};
                    table_bytes[hit] = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                    awaited_results.push_back(entry_result(STATUS_EXISTING, hit, 0, 1'b1));
                end else if (flows_held >= FLOW_ENTRIES) begin
                    awaited_results.push_back(blank_result(STATUS_DROPPED));
                end else begin
                    table_key[flows_held]   = k;
                    table_bytes[flows_held] = BYTES_W'(c.frame_len);
                    flows_held++;
                    awaited_results.push_back(entry_result(STATUS_NEW, flows_held - 1, 0, 1'b1));
                end
            end
            OP_READ: begin
                if (c.read_index < flows_held) begin
                    awaited_results.push_back(entry_result(STATUS_ENTRY, c.read_index, 0, 1'b1));
                end else begin
                    awaited_results.push_back(blank_result(STATUS_NO_ENTRY));
                end
            end
            OP_TOP: begin
                if (flows_held == 0) begin
                    awaited_results.push_back(blank_result(STATUS_NO_ENTRY));
                end else begin
                    n = flows_held;
                    if (n > TOP_COUNT) n = TOP_COUNT;
                    if (n > MAX_RESULTS) n = MAX_RESULTS;
                    taken = '{default: 1'b0};
                    for (int r = 0; r < n; r++) begin
                        best = -1;
                        for (int i = 0; i < flows_held; i++) begin
                            if (!taken[i] && (best < 0 || table_bytes[i] >= table_bytes[best])) begin
                                best = i;
                            end
                        end
                        taken[best] = 1'b1;
                        awaited_results.push_back(entry_result(STATUS_ENTRY, best, r, r == n - 1));
                    end
                end
            end
            default: begin
                flows_held = 0;
            end
        endcase
    endtask

    function automatic logic [S_TDATA_W-1:0] pack_beat(flow_cmd_t c);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[IN_SRC_IP_LSB +: IP_W]         = c.key.src_ip;
        d[IN_DST_IP_LSB +: IP_W]         = c.key.dst_ip;
        d[IN_PROTO_LSB  +: PROTO_W]      = c.key.proto;
        d[IN_SPORT_LSB  +: PORT_W]       = c.key.sport;
        d[IN_DPORT_LSB  +: PORT_W]       = c.key.dport;
        d[IN_LEN_LSB    +: LEN_W]        = c.frame_len;
        d[IN_READ_LSB   +: READ_INDEX_W] = c.read_index;
        return d;
    endfunction

    task automatic check_result();
        flow_result_t want;
        if (awaited_results.size() == 0) begin
            report_error($sformatf("result beat with status %0d arrived unpredicted", m_tuser));
            return;
        end
        want = awaited_results.pop_front();
        check_field("status", m_tuser, want.status);
        check_field("flow_index", m_tdata[OUT_IDX_LSB +: FLOW_INDEX_W], want.flow_index);
        check_field("flow_count", m_tdata[OUT_CNT_LSB +: FLOW_COUNT_W], want.flow_count);
        check_field("byte_total", m_tdata[OUT_BYTES_LSB +: BYTES_W], want.byte_total);
        check_field("key_src_ip", m_tdata[OUT_SRC_IP_LSB +: IP_W], want.key.src_ip);
        check_field("key_dst_ip", m_tdata[OUT_DST_IP_LSB +: IP_W], want.key.dst_ip);
        check_field("key_proto", m_tdata[OUT_PROTO_LSB +: PROTO_W], want.key.proto);
        check_field("key_sport", m_tdata[OUT_SPORT_LSB +: PORT_W], want.key.sport);
        check_field("key_dport", m_tdata[OUT_DPORT_LSB +: PORT_W], want.key.dport);
        check_field("rank", m_tdata[OUT_RANK_LSB +: RANK_W], want.rank);
        check_field("last", m_tlast, want.last);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) account_beat(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() > 0 &&
                    $urandom_range(99) >= TX_IDLE_PCT[pending_beats[0].phase]) begin
                    cur_cmd = pending_beats.pop_front();
                    cur_phase <= cur_cmd.phase;
                    s_tdata   <= pack_beat(cur_cmd);
                    s_tuser   <= cur_cmd.op;
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            m_tready <= ($urandom_range(99) >= RX_STALL_PCT[cur_phase]);
        end
    end

    function automatic key_t random_key();
        key_t k;
        k.src_ip = $urandom;
        k.dst_ip = $urandom;
        case ($urandom_range(4))
            0, 1:    k.proto = TCP_PROTO_NUM;
            2, 3:    k.proto = UDP_PROTO_NUM;
            default: k.proto = PROTO_W'($urandom_range(255));
        endcase
        k.sport = PORT_W'($urandom_range(65535));
        k.dport = PORT_W'($urandom_range(65535));
        return k;
    endfunction

    function automatic flow_cmd_t random_cmd(op_t op, int ph);
        flow_cmd_t c;
        c.op         = op;
        c.key        = random_key();
        c.frame_len  = LEN_W'($urandom_range(65535));
        c.read_index = READ_INDEX_W'($urandom_range(63));
        c.phase      = ph;
        return c;
    endfunction

    task automatic push_op(input op_t op, input int ri, input int ph);
        flow_cmd_t c;
        c = random_cmd(op, ph);
        c.read_index = READ_INDEX_W'(ri);
        pending_beats.push_back(c);
    endtask

    task automatic push_packet(input logic [IP_W-1:0] sip, input logic [IP_W-1:0] dip,
                               input logic [PROTO_W-1:0] pr, input logic [PORT_W-1:0] sp,
                               input logic [PORT_W-1:0] dp, input logic [LEN_W-1:0] len);
        flow_cmd_t c;
        c = random_cmd(OP_PACKET, 0);
        c.key.src_ip = sip;
        c.key.dst_ip = dip;
        c.key.proto  = pr;
        c.key.sport  = sp;
        c.key.dport  = dp;
        c.frame_len  = len;
        pending_beats.push_back(c);
    endtask

    task automatic queue_mixed(input int count, input int new_pct, input int clear_pct,
                               input int ph);
        flow_cmd_t c;
        key_t      k;
        int        sel;
        int        top_ri;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < clear_pct) begin
                c = random_cmd(OP_CLEAR, ph);
                if ($urandom_range(1)) flow_pool.delete();
            end else if (sel < 72) begin
                c = random_cmd(OP_PACKET, ph);
                if (flow_pool.size() > 0 && $urandom_range(99) >= new_pct) begin
                    k = flow_pool[$urandom_range(flow_pool.size() - 1)];
                    if (k.proto != TCP_PROTO_NUM && k.proto != UDP_PROTO_NUM) begin
                        k.sport = PORT_W'($urandom_range(65535));
                        k.dport = PORT_W'($urandom_range(65535));
                    end
                    c.key = k;
                end else begin
                    flow_pool.push_back(c.key);
                end
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(3))
                        0:       c.frame_len = '0;
                        1:       c.frame_len = 16'd64;
                        2:       c.frame_len = 16'd1500;
                        default: c.frame_len = '1;
                    endcase
                end
            end else if (sel < 86) begin
                c = random_cmd(OP_READ, ph);
                if ($urandom_range(1)) begin
                    top_ri = flow_pool.size() < 63 ? flow_pool.size() : 63;
                    c.read_index = READ_INDEX_W'($urandom_range(top_ri));
                end
            end else begin
                c = random_cmd(OP_TOP, ph);
            end
            pending_beats.push_back(c);
        end
    endtask

    initial begin
        flow_cmd_t c;
        key_t      heavy;

        // Empty table: clear, top report and reads have nothing to show.
        push_op(OP_CLEAR, 0, 0);
        push_op(OP_TOP, 0, 0);
        push_op(OP_READ, 0, 0);
        push_op(OP_READ, 63, 0);
        // Field extremes, ignored ports for other protocols, and a three-way tie.
        push_packet('0, '0, 8'd0, '0, '0, '0);
        push_packet('1, '1, 8'hFF, '1, '1, 16'd1);
        push_packet('1, '1, 8'hFF, 16'h1234, 16'h8001, 16'd9);
        push_packet('1, '1, UDP_PROTO_NUM, '1, '1, '1);
        push_packet('1, '1, UDP_PROTO_NUM, 16'hFFFE, '1, 16'd300);
        push_packet('1, '1, TCP_PROTO_NUM, '1, '1, 16'd300);
        push_packet('0, '0, 8'd0, 16'h5555, 16'hAAAA, 16'd300);
        push_op(OP_TOP, 0, 0);
        push_op(OP_READ, 4, 0);
        push_op(OP_READ, 5, 0);
        push_op(OP_READ, 63, 0);
        push_op(OP_CLEAR, 0, 0);
        push_op(OP_TOP, 0, 0);
        push_packet(32'h0A000001, 32'hC0A80001, TCP_PROTO_NUM, 16'd80, 16'd443, 16'd1500);
        push_op(OP_TOP, 0, 0);
        push_packet(32'h0A000001, 32'hC0A80002, TCP_PROTO_NUM, 16'd80, 16'd443, 16'd1500);
        push_op(OP_TOP, 0, 0);
        push_op(OP_READ, 1, 0);

        queue_mixed(RANDOM_PER_PHASE, 35, 3, 0);
        push_op(OP_CLEAR, 0, 1);
        flow_pool.delete();
        queue_mixed(RANDOM_PER_PHASE, 85, 0, 1);
        queue_mixed(RANDOM_PER_PHASE, 35, 3, 2);

        // One flow that keeps growing at the largest frame size.
        push_op(OP_CLEAR, 0, 2);
        heavy = random_key();
        heavy.proto = TCP_PROTO_NUM;
        for (int n = 0; n < HEAVY_BEATS; n++) begin
            c = random_cmd(OP_PACKET, 2);
            c.key = heavy;
            c.frame_len = '1;
            pending_beats.push_back(c);
        end
        push_op(OP_READ, 0, 2);
        push_op(OP_TOP, 0, 2);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (200) @(posedge aclk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
